// File: rtl/midi_event_gap_grouper_defines.svh
// ----------------------------------------------------------------------------
// midi_event_gap_grouper_defines.svh
// Assertion macros used by the grouper top module.
// ----------------------------------------------------------------------------
`ifndef MIDI_EVENT_GAP_GROUPER_DEFINES_SVH
`define MIDI_EVENT_GAP_GROUPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEVG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MEVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mevg_pkg.sv
// ----------------------------------------------------------------------------
// mevg_pkg
// Shared constants, types and register codes of the MIDI event gap grouper.
// ----------------------------------------------------------------------------
package mevg_pkg;

	localparam int DEF_GROUP_DEPTH = 16;
	localparam int DEF_TIME_BITS   = 48;

	localparam int NUM_W     = 7;
	localparam int VAL_W     = 7;
	localparam int ENTRY_W   = NUM_W + VAL_W;
	localparam int STAMP_W   = 48;
	localparam int GAP_W     = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [GAP_W-1:0] NOTE_GAP_RESET = 24'd1200;
	localparam logic [GAP_W-1:0] CTRL_GAP_RESET = 24'd3000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_GAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_GAP = 1'b1;

	// event / group kinds
	localparam logic KIND_NOTE = 1'b0;
	localparam logic KIND_CTRL = 1'b1;

	typedef struct packed {
		logic [GAP_W-1:0] note_gap;
		logic [GAP_W-1:0] ctrl_gap;
	} gap_cfg_t;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] number;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic push;   // take a new candidate item
		logic flush;  // release held item as last of the run
		logic ovf;    // overflow flag for the last item
	} emit_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FLUSH,
		ST_WRITE
	} mevg_state_t;

endpackage

// File: rtl/mevg_if.sv
// ----------------------------------------------------------------------------
// mevg_if
// Valid/ready channels of the grouper: events in, results out, config writes.
// ----------------------------------------------------------------------------
interface mevg_event_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [mevg_pkg::NUM_W-1:0]  event_number;
	logic [mevg_pkg::VAL_W-1:0]  control_value;
	logic [mevg_pkg::STAMP_W-1:0] event_time;

	modport source (output valid, req_type, event_number, control_value, event_time,
		input ready);
	modport sink (input valid, req_type, event_number, control_value, event_time,
		output ready);
endinterface

interface mevg_result_if;
	logic                       valid;
	logic                       ready;
	logic                       group_kind;
	logic [mevg_pkg::NUM_W-1:0] item_number;
	logic [mevg_pkg::VAL_W-1:0] item_value;
	logic                       last_in_group;
	logic                       group_overflowed;

	modport source (output valid, group_kind, item_number, item_value, last_in_group,
		group_overflowed, input ready);
	modport sink (input valid, group_kind, item_number, item_value, last_in_group,
		group_overflowed, output ready);
endinterface

interface mevg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mevg_pkg::CFG_IDX_W-1:0] index;
	logic [mevg_pkg::GAP_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mevg_ram.sv
// ----------------------------------------------------------------------------
// mevg_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mevg_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 14
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/mevg_cfg.sv
// ----------------------------------------------------------------------------
// mevg_cfg
// Gap limit registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module mevg_cfg (
	input  logic               clk,
	input  logic               arst_n,
	mevg_cfg_if.sink           cfg,
	output mevg_pkg::gap_cfg_t gaps
);
	import mevg_pkg::*;

	gap_cfg_t gaps_q;

	assign cfg.ready = 1'b1;
	assign gaps      = gaps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gaps_q.note_gap <= NOTE_GAP_RESET;
			gaps_q.ctrl_gap <= CTRL_GAP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NOTE_GAP: gaps_q.note_gap <= cfg.data;
				REG_CTRL_GAP: gaps_q.ctrl_gap <= cfg.data;
			endcase
		end
	end
endmodule

// File: rtl/mevg_emit.sv
// ----------------------------------------------------------------------------
// mevg_emit
// Result staging: one held item plus the output register. The held item goes
// out when the next one arrives, or marked last when the run is flushed.
// ----------------------------------------------------------------------------
module mevg_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  mevg_pkg::emit_cmd_t cmd,
	input  mevg_pkg::item_t     cand,
	output logic                room,
	mevg_result_if.source       res
);
	import mevg_pkg::*;

	item_t pend_q;
	logic  pend_v_q;
	item_t out_q;
	logic  out_v_q;
	logic  out_last_q;
	logic  out_ovf_q;
	logic  out_free;

	assign out_free = !out_v_q || res.ready;
	assign room     = !pend_v_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			priority if (cmd.push) begin
				pend_v_q <= 1'b1;
				out_v_q  <= pend_v_q || (out_v_q && !res.ready);
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= pend_v_q || (out_v_q && !res.ready);
			end else begin
				out_v_q  <= out_v_q && !res.ready;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_q <= cand;
		end
		if ((cmd.push || cmd.flush) && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
			out_ovf_q  <= cmd.flush && cmd.ovf;
		end
	end

	assign res.valid            = out_v_q;
	assign res.group_kind       = out_q.kind;
	assign res.item_number      = out_q.number;
	assign res.item_value       = out_q.value;
	assign res.last_in_group    = out_last_q;
	assign res.group_overflowed = out_ovf_q;
endmodule

// File: rtl/midi_event_gap_grouper.sv
// ----------------------------------------------------------------------------
// midi_event_gap_grouper
// An accepted event goes through CHECK and then WRITE; one that closes a group
// goes through SCAN and FLUSH before WRITE. The scan reads one entry per cycle,
// while the emitter has room or the entry is dropped, through the single read
// port of the group RAM. A new event is taken only in IDLE, after the last.
// Reset clears counts, overflow flags and last-event time and loads the default
// gap limits; the group RAM is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
`include "midi_event_gap_grouper_defines.svh"

module midi_event_gap_grouper #(
	parameter int GROUP_DEPTH = mevg_pkg::DEF_GROUP_DEPTH,
	parameter int TIME_BITS   = mevg_pkg::DEF_TIME_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	mevg_event_if.sink    evt,
	mevg_result_if.source res,
	mevg_cfg_if.sink      cfg
);
	import mevg_pkg::*;

	localparam int IDX_W  = $clog2(GROUP_DEPTH);
	localparam int CNT_W  = $clog2(GROUP_DEPTH + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int CMP_W  = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(GROUP_DEPTH);

	mevg_state_t state_q, state_d;

	gap_cfg_t gaps;

	// latched event
	logic                 kind_q;
	logic [NUM_W-1:0]     num_q;
	logic [VAL_W-1:0]     val_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] last_q;

	logic [CNT_W-1:0] note_cnt_q;
	logic [CNT_W-1:0] ctrl_cnt_q;
	logic             note_ovf_q;
	logic             ctrl_ovf_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             s1_valid_q;

	logic [CNT_W-1:0]     cnt_sel;
	logic                 ovf_sel;
	logic [GAP_W-1:0]     limit_sel;
	logic [TIME_BITS-1:0] diff;
	logic                 gap_hit;

	logic               evt_ready;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [ENTRY_W-1:0] wr_data;
	logic               more;
	logic               drop_s1;
	logic               consume;
	logic               room;
	logic               clear_grp;
	emit_cmd_t          cmd;
	item_t              cand;

	mevg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.gaps   (gaps)
	);

	assign cnt_sel   = kind_q ? ctrl_cnt_q : note_cnt_q;
	assign ovf_sel   = kind_q ? ctrl_ovf_q : note_ovf_q;
	assign limit_sel = kind_q ? gaps.ctrl_gap : gaps.note_gap;
	// earlier stamps count as no gap
	assign diff      = now_q - last_q;
	assign gap_hit   = (now_q > last_q) && (CMP_W'(diff) > CMP_W'(limit_sel));

	assign more    = scan_idx_q < cnt_sel;
	// stored controller pairs with the incoming number leave the run
	assign drop_s1 = (kind_q == KIND_CTRL) && (rd_data[ENTRY_W-1:VAL_W] == num_q);
	assign consume = s1_valid_q && (drop_s1 || room);

	assign cand.kind   = kind_q;
	assign cand.number = rd_data[ENTRY_W-1:VAL_W];
	assign cand.value  = rd_data[VAL_W-1:0];

	assign wr_data = (kind_q == KIND_CTRL) ? {num_q, val_q} : {num_q, VAL_W'(0)};

	mevg_ram #(
		.DEPTH (2 ** ADDR_W),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({kind_q, cnt_sel[IDX_W-1:0]}),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr ({kind_q, scan_idx_q[IDX_W-1:0]}),
		.rd_data (rd_data)
	);

	mevg_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cand   (cand),
		.room   (room),
		.res    (res)
	);

	assign evt.ready = evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		evt_ready = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		clear_grp = 1'b0;
		cmd       = '0;
		cmd.ovf   = ovf_sel;
		unique case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = gap_hit ? ST_SCAN : ST_WRITE;
			end
			ST_SCAN: begin
				cmd.push = s1_valid_q && !drop_s1 && room;
				rd_en    = more && (!s1_valid_q || consume);
				if (!more && (!s1_valid_q || consume)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = room;
				if (room) begin
					clear_grp = 1'b1;
					state_d   = ST_WRITE;
				end
			end
			ST_WRITE: begin
				wr_en   = cnt_sel < CNT_FULL;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt_ready) begin
			kind_q <= evt.req_type;
			num_q  <= evt.event_number;
			val_q  <= evt.control_value;
			now_q  <= TIME_BITS'(evt.event_time);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			note_cnt_q <= '0;
			ctrl_cnt_q <= '0;
			note_ovf_q <= 1'b0;
			ctrl_ovf_q <= 1'b0;
			scan_idx_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CHECK) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end

			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (consume) begin
				s1_valid_q <= 1'b0;
			end

			if (clear_grp) begin
				if (kind_q == KIND_CTRL) begin
					ctrl_cnt_q <= '0;
					ctrl_ovf_q <= 1'b0;
				end else begin
					note_cnt_q <= '0;
					note_ovf_q <= 1'b0;
				end
			end

			if (state_q == ST_WRITE) begin
				last_q <= now_q;
				if (kind_q == KIND_CTRL) begin
					if (wr_en) begin
						ctrl_cnt_q <= ctrl_cnt_q + CNT_W'(1);
					end else begin
						ctrl_ovf_q <= 1'b1;
					end
				end else begin
					if (wr_en) begin
						note_cnt_q <= note_cnt_q + CNT_W'(1);
					end else begin
						note_ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	`MEVG_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, (note_cnt_q <= CNT_FULL) && (ctrl_cnt_q <= CNT_FULL), "group count above depth")
	`MEVG_ASSERT_NOW(a_s1_in_scan, clk, arst_n, s1_valid_q, state_q == ST_SCAN, "read data pending outside scan")
	`MEVG_ASSERT_NEXT(a_flush_clears, clk, arst_n, clear_grp, (cnt_sel == '0) && !ovf_sel, "closed group not cleared")
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midi_event_gap_grouper. Timestamped note and
// controller events go in on a valid/ready channel and released group items
// come out on another, both with random gaps and stalls. A predictor of the
// chord and burst stores tracks every accepted event and queues the items it
// should release. Each released word is compared against that queue. The gap
// limits are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import mevg_pkg::*;

	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_EVENTS   = 75;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] number;
		logic [VAL_W-1:0] value;
		logic [STAMP_W-1:0] stamp;
	} midi_event_t;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] number;
		logic [VAL_W-1:0] value;
		logic             last;
		logic             lost;
	} group_item_t;

	logic clk;
	logic arst_n;

	mevg_event_if  evt_bus ();
	mevg_result_if res_bus ();
	mevg_cfg_if    cfg_bus ();

	midi_event_gap_grouper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	// predictor state
	logic [NUM_W-1:0]   chord_notes [DEF_GROUP_DEPTH];
	int                 chord_len   = 0;
	bit                 chord_lost  = 1'b0;
	logic [ENTRY_W-1:0] burst_ctrls [DEF_GROUP_DEPTH];
	int                 burst_len   = 0;
	bit                 burst_lost  = 1'b0;
	logic [STAMP_W-1:0] last_stamp  = '0;
	logic [GAP_W-1:0]   note_limit  = NOTE_GAP_RESET;
	logic [GAP_W-1:0]   ctrl_limit  = CTRL_GAP_RESET;

	midi_event_t  pending_events[$];
	group_item_t  expected_releases[$];
	int           mismatches = 0;

	midi_event_t  evt_word;
	bit           evt_busy    = 1'b0;
	int           evt_pause   = 0;
	bit           evt_steady  = 1'b0;
	int           res_stall   = 0;
	bit           res_steady  = 1'b0;
	group_item_t  seen_word;
	group_item_t  want_word;
	int           quiet_cycles = 0;
	logic [STAMP_W-1:0] stamp_base = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n                = 1'b0;
		evt_bus.valid         = 1'b0;
		evt_bus.req_type      = KIND_NOTE;
		evt_bus.event_number  = '0;
		evt_bus.control_value = '0;
		evt_bus.event_time    = '0;
		res_bus.ready         = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = REG_NOTE_GAP;
		cfg_bus.data          = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int draw_pause(inout bit steady);
		if ($urandom_range(0, 15) == 0)
			steady = !steady;
		return steady ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic bit gap_over(input logic [STAMP_W-1:0] now,
		input logic [GAP_W-1:0] lim);
		if (now <= last_stamp)
			return 1'b0;
		return (now - last_stamp) > STAMP_W'(lim);
	endfunction

	// update the stores for one accepted event, queue whatever it releases
	function automatic void absorb_event(input midi_event_t ev);
		group_item_t      run[$];
		group_item_t      w;
		logic [GAP_W-1:0] lim;
		bit               lost;
		lim = (ev.kind == KIND_NOTE) ? note_limit : ctrl_limit;
		if (gap_over(ev.stamp, lim)) begin
			if (ev.kind == KIND_NOTE) begin
				for (int i = 0; i < chord_len; i++) begin
					w        = '0;
					w.kind   = KIND_NOTE;
					w.number = chord_notes[i];
					run      = {run, w};
				end
				lost       = chord_lost;
				chord_len  = 0;
				chord_lost = 1'b0;
			end else begin
				// pairs sharing the incoming controller number are dropped
				for (int i = 0; i < burst_len; i++) begin
					if (burst_ctrls[i][ENTRY_W-1:VAL_W] != ev.number) begin
						w        = '0;
						w.kind   = KIND_CTRL;
						w.number = burst_ctrls[i][ENTRY_W-1:VAL_W];
						w.value  = burst_ctrls[i][VAL_W-1:0];
						run      = {run, w};
					end
				end
				lost       = burst_lost;
				burst_len  = 0;
				burst_lost = 1'b0;
			end
			if (run.size() != 0) begin
				run[$].last = 1'b1;
				run[$].lost = lost;
			end
			expected_releases = {expected_releases, run};
		end
		if (ev.kind == KIND_NOTE) begin
			if (chord_len < DEF_GROUP_DEPTH) begin
				chord_notes[chord_len] = ev.number;
				chord_len++;
			end else
				chord_lost = 1'b1;
		end else begin
			if (burst_len < DEF_GROUP_DEPTH) begin
				burst_ctrls[burst_len] = {ev.number, ev.value};
				burst_len++;
			end else
				burst_lost = 1'b1;
		end
		last_stamp = ev.stamp;
	endfunction

	// event driver
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_bus.valid <= 1'b0;
			evt_busy = 1'b0;
			evt_pause = 0;
		end else begin
			if (evt_busy && evt_bus.valid && evt_bus.ready) begin
				absorb_event(evt_word);
				evt_busy = 1'b0;
				evt_pause = draw_pause(evt_steady);
			end
			if (!evt_busy) begin
				if (evt_pause > 0)
					evt_pause--;
				else if (pending_events.size() != 0) begin
					evt_word = pending_events.pop_front();
					evt_busy = 1'b1;
					evt_bus.req_type      <= evt_word.kind;
					evt_bus.event_number  <= evt_word.number;
					evt_bus.control_value <= evt_word.value;
					evt_bus.event_time    <= evt_word.stamp;
				end
			end
			evt_bus.valid <= evt_busy;
		end
	end

	// release monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			res_stall = 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				seen_word.kind   = res_bus.group_kind;
				seen_word.number = res_bus.item_number;
				seen_word.value  = res_bus.item_value;
				seen_word.last   = res_bus.last_in_group;
				seen_word.lost   = res_bus.group_overflowed;
				if (expected_releases.size() == 0) begin
					$display("%0t: unexpected word kind %0d num %0d val %0d last %0d ovf %0d",
						$time, seen_word.kind, seen_word.number, seen_word.value,
						seen_word.last, seen_word.lost);
					mismatches++;
				end else begin
					want_word = expected_releases.pop_front();
					if (seen_word !== want_word) begin
						$display("%0t: expected kind %0d num %0d val %0d last %0d ovf %0d",
							$time, want_word.kind, want_word.number, want_word.value,
							want_word.last, want_word.lost);
						$display("%0t:   actual kind %0d num %0d val %0d last %0d ovf %0d",
							$time, seen_word.kind, seen_word.number, seen_word.value,
							seen_word.last, seen_word.lost);
						mismatches++;
					end
				end
				res_stall = draw_pause(res_steady);
			end
			if (res_stall > 0) begin
				res_stall--;
				res_bus.ready <= 1'b0;
			end else
				res_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic push_event(input logic kind, input int number, input int value,
		input logic [STAMP_W-1:0] stamp);
		midi_event_t ev;
		ev.kind   = kind;
		ev.number = NUM_W'(number);
		ev.value  = VAL_W'(value);
		ev.stamp  = stamp;
		pending_events = {pending_events, ev};
	endtask

	task automatic write_gap(input logic [CFG_IDX_W-1:0] idx,
		input logic [GAP_W-1:0] limit);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= limit;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_NOTE_GAP)
			note_limit = limit;
		else
			ctrl_limit = limit;
	endtask

	// block must be idle: nothing queued, in flight or outstanding
	task automatic wait_drained();
		while (pending_events.size() != 0 || evt_busy || expected_releases.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one chord or burst: a gap at or past the limit, then members inside it
	task automatic queue_burst(input logic [GAP_W-1:0] ng, input logic [GAP_W-1:0] cg,
		inout int queued);
		logic               kind;
		logic [STAMP_W-1:0] lim;
		logic [STAMP_W-1:0] step;
		int                 len;
		int                 num;
		if ($urandom_range(0, 7) == 0) begin
			stamp_base = STAMP_W'({$urandom, $urandom});
			push_event(1'($urandom_range(0, 1)), $urandom_range(0, 127),
				$urandom_range(0, 127), stamp_base);
			queued++;
			return;
		end
		kind = 1'($urandom_range(0, 1));
		lim  = (kind == KIND_NOTE) ? STAMP_W'(ng) : STAMP_W'(cg);
		len  = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
		case ($urandom_range(0, 3))
			0: step = lim;
			1: step = lim + 1;
			default: step = lim + 1 + $urandom_range(0, 4000);
		endcase
		stamp_base += step;
		for (int k = 0; k < len; k++) begin
			if (kind == KIND_CTRL)
				// small number pool so repeats within a burst are common
				num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
			else
				num = $urandom_range(0, 127);
			push_event(kind, num, $urandom_range(0, 127), stamp_base);
			queued++;
			case ($urandom_range(0, 5))
				0, 1: ;
				2: stamp_base -= $urandom_range(1, 50);
				default: stamp_base += $urandom_range(0, (lim > 4000) ? 4000 : int'(lim));
			endcase
		end
	endtask

	initial begin
		logic [GAP_W-1:0] ng;
		logic [GAP_W-1:0] cg;
		int               queued;
		wait (arst_n === 1'b1);

		// directed part, gap limits at reset values
		push_event(KIND_NOTE, 0, 0, 48'd5000);      // first close finds an empty chord
		push_event(KIND_NOTE, 127, 127, 48'd6200);  // gap equal to limit joins
		push_event(KIND_NOTE, 5, 0, 48'd7401);      // one past limit releases
		push_event(KIND_CTRL, 127, 127, 48'd7401);
		push_event(KIND_CTRL, 0, 0, 48'd7402);
		push_event(KIND_CTRL, 127, 5, 48'd10403);   // releases, same number filtered
		push_event(KIND_NOTE, 64, 0, 48'd100);      // time runs backwards, joins
		for (int k = 0; k < 16; k++)                // chord fills and overflows
			push_event(KIND_NOTE, $urandom_range(0, 127), $urandom_range(0, 127), 48'd100);
		push_event(KIND_NOTE, 3, 0, 48'hFFFF_FFFF_EC77);
		// every stored pair matches the incoming number: nothing released
		push_event(KIND_CTRL, 127, 1, 48'hFFFF_FFFF_FFFF);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin ng = '0; cg = '0; end
				1: begin ng = '1; cg = '1; end
				2: begin ng = NOTE_GAP_RESET; cg = CTRL_GAP_RESET; end
				3: begin ng = '0; cg = '1; end
				default: begin
					ng = GAP_W'($urandom_range(0, 6000));
					cg = GAP_W'($urandom_range(0, 6000));
				end
			endcase
			write_gap(REG_NOTE_GAP, ng);
			write_gap(REG_CTRL_GAP, cg);
			stamp_base = STAMP_W'($urandom);
			queued = 0;
			while (queued < PHASE_EVENTS)
				queue_burst(ng, cg, queued);
			wait_drained();
		end

		if (mismatches == 0 && expected_releases.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: midi_event_gap_grouper.f
+incdir+rtl
rtl/mevg_pkg.sv
rtl/mevg_if.sv
rtl/mevg_ram.sv
rtl/mevg_cfg.sv
rtl/mevg_emit.sv
rtl/midi_event_gap_grouper.sv
sim/tb.sv
